### sv/sha1md_pkg.sv
// Shared types and constants for the SHA-1 message digest block.
`default_nettype none

package sha1md_pkg;

	typedef logic [31:0] word_t;

	localparam int NUM_CHAIN  = 5;
	localparam int NUM_ROUNDS = 80;
	localparam int BLK_WORDS  = 16;

	localparam word_t SHA1_IV [NUM_CHAIN] = '{
		32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
	};

	localparam word_t K_R0 = 32'h5A827999;
	localparam word_t K_R1 = 32'h6ED9EBA1;
	localparam word_t K_R2 = 32'h8F1BBCDC;
	localparam word_t K_R3 = 32'hCA62C1D6;

	localparam logic [7:0] PAD_BYTE = 8'h80;

	// Requests from the framing logic to the compression core.
	typedef struct packed {
		logic  push;   // shift one schedule word into the block
		word_t word;
		logic  start;  // compress the sixteen words held
		logic  init;   // return the chaining value to the initial value
	} core_ctl_t;

	typedef struct packed {
		logic busy;
		logic done;    // one-cycle pulse after the chaining value is updated
	} core_sts_t;

endpackage

`default_nettype wire

### sv/sha1md_core.sv
// SHA-1 compression core: schedule shift line and one shared round unit.
`default_nettype none

module sha1md_core
	import sha1md_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire core_ctl_t ctl,
	output core_sts_t      sts,
	output word_t          digest [NUM_CHAIN]
);

	typedef enum logic [1:0] {C_IDLE, C_ROUND, C_ADD} core_state_t;

	core_state_t state_q;
	logic [6:0]  rnd_q;
	logic        done_q;
	word_t       w_q [BLK_WORDS];
	word_t       h_q [NUM_CHAIN];
	word_t       a_q, b_q, c_q, d_q, e_q;

	word_t f_val, k_val, t_val, w_new, w_mix;

	always_comb begin
		priority if (rnd_q < 7'd20) begin
			f_val = (b_q & c_q) | (~b_q & d_q);
			k_val = K_R0;
		end else if (rnd_q < 7'd40) begin
			f_val = b_q ^ c_q ^ d_q;
			k_val = K_R1;
		end else if (rnd_q < 7'd60) begin
			f_val = (b_q & c_q) | (b_q & d_q) | (c_q & d_q);
			k_val = K_R2;
		end else begin
			f_val = b_q ^ c_q ^ d_q;
			k_val = K_R3;
		end
		t_val = {a_q[26:0], a_q[31:27]} + f_val + e_q + w_q[0] + k_val;
		// The window holds w[t..t+15]; the next word is w[t+16].
		w_mix = w_q[13] ^ w_q[8] ^ w_q[2] ^ w_q[0];
		w_new = {w_mix[30:0], w_mix[31]};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= C_IDLE;
			rnd_q   <= '0;
			done_q  <= 1'b0;
			h_q     <= SHA1_IV;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				C_IDLE: begin
					if (ctl.push) begin
						for (int i = 0; i < BLK_WORDS - 1; i++) w_q[i] <= w_q[i + 1];
						w_q[BLK_WORDS - 1] <= ctl.word;
					end
					if (ctl.init) h_q <= SHA1_IV;
					if (ctl.start) begin
						a_q     <= h_q[0];
						b_q     <= h_q[1];
						c_q     <= h_q[2];
						d_q     <= h_q[3];
						e_q     <= h_q[4];
						rnd_q   <= '0;
						state_q <= C_ROUND;
					end
				end
				C_ROUND: begin
					for (int i = 0; i < BLK_WORDS - 1; i++) w_q[i] <= w_q[i + 1];
					w_q[BLK_WORDS - 1] <= w_new;
					a_q   <= t_val;
					b_q   <= a_q;
					c_q   <= {b_q[1:0], b_q[31:2]};
					d_q   <= c_q;
					e_q   <= d_q;
					rnd_q <= rnd_q + 7'd1;
					if (rnd_q == 7'(NUM_ROUNDS - 1)) state_q <= C_ADD;
				end
				C_ADD: begin
					h_q[0]  <= h_q[0] + a_q;
					h_q[1]  <= h_q[1] + b_q;
					h_q[2]  <= h_q[2] + c_q;
					h_q[3]  <= h_q[3] + d_q;
					h_q[4]  <= h_q[4] + e_q;
					done_q  <= 1'b1;
					state_q <= C_IDLE;
				end
				default: state_q <= C_IDLE;
			endcase
		end
	end

	assign sts.busy = (state_q != C_IDLE);
	assign sts.done = done_q;
	assign digest   = h_q;

`ifndef SYNTHESIS
	a_push_idle: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.push |-> state_q == C_IDLE)
		else $error("schedule word pushed during compression");
	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.start |-> state_q == C_IDLE)
		else $error("compression started while busy");
	a_done_after_add: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> $past(state_q == C_ADD))
		else $error("done pulse without a final add");
	a_round_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == C_ROUND |-> rnd_q < 7'(NUM_ROUNDS))
		else $error("round counter out of range");
`endif

endmodule

`default_nettype wire

### sv/sha1_message_digest.sv
// SHA-1 message digest: byte framing, padding and digest output around the core.
`default_nettype none

// Bytes arrive one per word on the slave stream; tlast closes the message and
// tuser set means the word carries no byte. Each full 64-byte block is
// compressed by one shared round unit, one round per cycle, in the steps start,
// 80 rounds, final add and done handshake, during which s_axis_tready is low.
// On the last word the block writes the padding and bit length one schedule
// word per cycle, pausing to compress the first block when an extra block is
// needed, then compresses and offers the five digest words H0 to H4 on the
// master stream, tlast on H4. After H4 is taken the chaining value and byte
// count return to their initial values.

module sha1_message_digest
	import sha1md_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [7:0]  s_axis_tdata,  // [7:0] data_byte
	input  wire logic        s_axis_tuser,  // [0] no_data
	input  wire logic        s_axis_tlast,  // end_of_message
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic [31:0]      m_axis_tdata,  // [31:0] digest_word
	output logic             m_axis_tlast   // last_word
);

	typedef enum logic [2:0] {
		S_IDLE, S_START, S_WAIT, S_PAD, S_ZERO, S_LEN, S_OUT
	} state_t;

	state_t      state_q, after_q;
	logic [60:0] count_q;
	logic [23:0] acc_q;
	logic [4:0]  wcnt_q;
	logic [2:0]  out_idx_q;

	core_ctl_t ctl;
	core_sts_t sts;
	word_t     digest [NUM_CHAIN];

	logic  in_acc, out_acc, has_byte, last_out;
	logic  [5:0] pos;
	word_t pad_word;

	assign s_axis_tready = (state_q == S_IDLE);
	assign in_acc   = s_axis_tvalid & s_axis_tready;
	assign has_byte = in_acc & ~s_axis_tuser;
	assign pos      = count_q[5:0];
	assign m_axis_tvalid = (state_q == S_OUT);
	assign m_axis_tdata  = digest[out_idx_q];
	assign m_axis_tlast  = (out_idx_q == 3'(NUM_CHAIN - 1));
	assign out_acc  = m_axis_tvalid & m_axis_tready;
	assign last_out = out_acc & m_axis_tlast;

	// The partial word keeps its bytes right-aligned; the 0x80 marker follows them.
	always_comb begin
		unique case (count_q[1:0])
			2'd0: pad_word = {PAD_BYTE, 24'h0};
			2'd1: pad_word = {acc_q[7:0], PAD_BYTE, 16'h0};
			2'd2: pad_word = {acc_q[15:0], PAD_BYTE, 8'h0};
			2'd3: pad_word = {acc_q[23:0], PAD_BYTE};
			default: pad_word = '0;
		endcase
	end

	always_comb begin
		ctl.start = (state_q == S_START);
		ctl.init  = last_out;
		ctl.push  = (has_byte && pos[1:0] == 2'd3) || (state_q == S_PAD) ||
			(state_q == S_ZERO && wcnt_q != 5'(BLK_WORDS)) || (state_q == S_LEN);
		priority case (state_q)
			S_PAD:  ctl.word = pad_word;
			S_ZERO: ctl.word = (wcnt_q == 5'(BLK_WORDS - 2)) ? count_q[60:29] : '0;
			S_LEN:  ctl.word = {count_q[28:0], 3'b000};
			default: ctl.word = {acc_q, s_axis_tdata};
		endcase
	end

	sha1md_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (ctl),
		.sts    (sts),
		.digest (digest)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			after_q   <= S_IDLE;
			count_q   <= '0;
			wcnt_q    <= '0;
			out_idx_q <= '0;
		end else begin
			if (ctl.push) wcnt_q <= wcnt_q + 5'd1;
			unique case (state_q)
				S_IDLE: begin
					if (has_byte) begin
						acc_q   <= {acc_q[15:0], s_axis_tdata};
						count_q <= count_q + 61'd1;
					end
					if (has_byte && pos == 6'd63) begin
						state_q <= S_START;
						after_q <= s_axis_tlast ? S_PAD : S_IDLE;
					end else if (in_acc && s_axis_tlast) begin
						state_q <= S_PAD;
					end
				end
				S_START: begin
					wcnt_q  <= '0;
					state_q <= S_WAIT;
				end
				S_WAIT: begin
					if (sts.done) state_q <= after_q;
				end
				S_PAD: state_q <= S_ZERO;
				S_ZERO: begin
					if (wcnt_q == 5'(BLK_WORDS)) begin
						// Not enough room for the length: close this block first.
						state_q <= S_START;
						after_q <= S_ZERO;
					end else if (wcnt_q == 5'(BLK_WORDS - 2)) begin
						state_q <= S_LEN;
					end
				end
				S_LEN: begin
					state_q <= S_START;
					after_q <= S_OUT;
				end
				S_OUT: begin
					if (out_acc) begin
						if (last_out) begin
							out_idx_q <= '0;
							count_q   <= '0;
							state_q   <= S_IDLE;
						end else begin
							out_idx_q <= out_idx_q + 3'd1;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

`default_nettype wire

### bench/tb_top.sv
`timescale 1ns / 1ps
// Self-checking stream bench for the SHA-1 message digest block.
module tb_top;
	import sha1md_pkg::*;

	localparam int CYCLE_LIMIT  = 200000;
	localparam int TAIL_CYCLES  = 250;
	localparam int IDLE_PERCENT = 11;

	typedef struct {
		word_t word;
		logic  last;
	} digest_beat_t;

	logic        clk;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [7:0]  s_axis_tdata;   // [7:0] data_byte
	logic        s_axis_tuser;   // [0] no_data
	logic        s_axis_tlast;   // end_of_message
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [31:0] m_axis_tdata;   // [31:0] digest_word
	logic        m_axis_tlast;   // last_word

	sha1_message_digest i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast)
	);

	// Running hash state of the predictor.
	word_t        hash_h [NUM_CHAIN];
	word_t        hash_blk [BLK_WORDS];
	logic [60:0]  hash_len;
	digest_beat_t digest_q [$];

	int     errors;
	int     n_items;
	int     n_messages;
	int     n_checked;
	longint cycles;
	bit     idle_on;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic word_t rol(input word_t v, input int s);
		return (v << s) | (v >> (32 - s));
	endfunction

	function automatic void hash_put(input int pos, input logic [7:0] v);
		hash_blk[pos >> 2][31 - 8 * (pos % 4) -: 8] = v;
	endfunction

	function automatic void hash_restart();
		for (int i = 0; i < NUM_CHAIN; i++)
			hash_h[i] = SHA1_IV[i];
		hash_len = '0;
	endfunction

	function automatic void sha1_compress();
		word_t w [NUM_ROUNDS];
		word_t a, b, c, d, e, f, k, t;
		for (int i = 0; i < 16; i++)
			w[i] = hash_blk[i];
		for (int i = 16; i < 32; i++)
			w[i] = rol(w[i-3] ^ w[i-8] ^ w[i-14] ^ w[i-16], 1);
		for (int i = 32; i < NUM_ROUNDS; i++)
			w[i] = rol(w[i-6] ^ w[i-16] ^ w[i-28] ^ w[i-32], 2);
		a = hash_h[0]; b = hash_h[1]; c = hash_h[2]; d = hash_h[3]; e = hash_h[4];
		for (int i = 0; i < NUM_ROUNDS; i++) begin
			if (i < 20) begin
				f = (b & c) | (~b & d);
				k = K_R0;
			end else if (i < 40) begin
				f = b ^ c ^ d;
				k = K_R1;
			end else if (i < 60) begin
				f = (b & c) | (b & d) | (c & d);
				k = K_R2;
			end else begin
				f = b ^ c ^ d;
				k = K_R3;
			end
			t = rol(a, 5) + f + e + w[i] + k;
			e = d; d = c; c = rol(b, 30); b = a; a = t;
		end
		hash_h[0] += a; hash_h[1] += b; hash_h[2] += c; hash_h[3] += d; hash_h[4] += e;
	endfunction

	// Takes one accepted word into the running hash; a closing word queues the digest.
	function automatic void hash_absorb(input logic [7:0] b, input logic nd, input logic eom);
		int           p;
		logic [63:0]  bits;
		digest_beat_t beat;
		if (!nd) begin
			p = int'(hash_len[5:0]);
			hash_put(p, b);
			hash_len++;
			if (p == 63)
				sha1_compress();
		end
		if (!eom)
			return;
		p = int'(hash_len[5:0]);
		hash_put(p, PAD_BYTE);
		for (int i = p + 1; i < 64; i++)
			hash_put(i, 8'h00);
		// With fewer than eight bytes left the length spills into an extra block.
		if (p >= 56) begin
			sha1_compress();
			for (int i = 0; i < BLK_WORDS; i++)
				hash_blk[i] = '0;
		end
		bits = {hash_len, 3'b000};
		hash_blk[14] = bits[63:32];
		hash_blk[15] = bits[31:0];
		sha1_compress();
		for (int i = 0; i < NUM_CHAIN; i++) begin
			beat.word = hash_h[i];
			beat.last = (i == NUM_CHAIN - 1);
			digest_q.push_back(beat);
		end
		hash_restart();
	endfunction

	task automatic report(input string msg);
		errors++;
		$display("MISMATCH at cycle %0d: %s", cycles, msg);
	endtask

	task automatic send_word(input logic [7:0] b, input logic nd, input logic eom);
		while (idle_on && $urandom_range(99) < IDLE_PERCENT) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= b;
		s_axis_tuser  <= nd;
		s_axis_tlast  <= eom;
		do
			@(posedge clk);
		while (!s_axis_tready);
		hash_absorb(b, nd, eom);
		n_items++;
		if (eom)
			n_messages++;
	endtask

	// Holds the sender off until every queued digest word has been taken.
	task automatic wait_for_digests();
		s_axis_tvalid <= 1'b0;
		do
			@(posedge clk);
		while (digest_q.size() != 0);
	endtask

	// Random bytes with the odd empty word in between; the close comes on the
	// last byte or on a separate empty word.
	task automatic send_message(input int len, input bit close_on_byte);
		for (int i = 0; i < len; i++) begin
			if ($urandom_range(99) < 8)
				send_word(8'($urandom_range(255)), 1'b1, 1'b0);
			send_word(8'($urandom_range(255)), 1'b0, close_on_byte && (i == len - 1));
		end
		if (!close_on_byte || len == 0)
			send_word(8'($urandom_range(255)), 1'b1, 1'b1);
	endtask

	task automatic test_directed();
		idle_on <= 1'b1;
		// Empty message, with a stray byte value that must be ignored.
		send_word(8'h5A, 1'b1, 1'b1);
		// "abc" with an empty word in the middle.
		send_word(8'h61, 1'b0, 1'b0);
		send_word(8'h62, 1'b0, 1'b0);
		send_word(8'hFF, 1'b1, 1'b0);
		send_word(8'h63, 1'b0, 1'b1);
		send_word(8'hFF, 1'b0, 1'b1);
		send_word(8'h00, 1'b0, 1'b1);
		send_word(8'h00, 1'b0, 1'b0);
		send_word(8'hFF, 1'b0, 1'b0);
		send_word(8'h00, 1'b1, 1'b1);
	endtask

	task automatic test_block_edges();
		wait_for_digests();
		idle_on <= 1'b1;
		// The closing byte fills the block, so padding needs a fresh one.
		send_message(64, 1'b1);
		// 56 bytes leave no room for the length in the same block.
		send_message(56, 1'b0);
	endtask

	task automatic test_random_messages(input int budget, input bit idling);
		int first;
		int len;
		idle_on <= idling;
		first = n_items;
		while (n_items - first < budget) begin
			if ($urandom_range(99) < 85)
				len = $urandom_range(12);
			else
				len = $urandom_range(70, 50);
			send_message(len, 1'($urandom_range(1)));
		end
	endtask

	always @(posedge clk) begin
		digest_beat_t exp_beat;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (digest_q.size() == 0) begin
				report($sformatf("digest word %08h with none expected", m_axis_tdata));
			end else begin
				exp_beat = digest_q.pop_front();
				if (m_axis_tdata !== exp_beat.word)
					report($sformatf("H%0d is %08h, expected %08h", n_checked % NUM_CHAIN,
						m_axis_tdata, exp_beat.word));
				if (m_axis_tlast !== exp_beat.last)
					report($sformatf("H%0d tlast is %b, expected %b", n_checked % NUM_CHAIN,
						m_axis_tlast, exp_beat.last));
				n_checked++;
			end
		end
		m_axis_tready <= !(idle_on && $urandom_range(99) < IDLE_PERCENT);
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("Timed out after %0d cycles, %0d digest words outstanding",
				cycles, digest_q.size());
			$display("RESULT: ERROR");
			$finish;
		end
	end

	initial begin
		arst_n        = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = 8'h00;
		s_axis_tuser  = 1'b0;
		s_axis_tlast  = 1'b0;
		m_axis_tready = 1'b0;
		idle_on       = 1'b0;
		errors        = 0;
		n_items       = 0;
		n_messages    = 0;
		n_checked     = 0;
		cycles        = 0;
		hash_restart();
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_block_edges();
		test_random_messages(25, 1'b0);
		test_random_messages(45, 1'b1);

		wait_for_digests();
		repeat (TAIL_CYCLES) @(posedge clk);
		$display("Hashed %0d messages from %0d words, %0d digest words checked.",
			n_messages, n_items, n_checked);
		$display("Included empty messages, ignored words and padding across block edges.");
		if (errors == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule

### filelist.f
sv/sha1md_pkg.sv
sv/sha1md_core.sv
sv/sha1_message_digest.sv
bench/tb_top.sv
